/* rtl/ealu_pkg.sv */
// package for the eight-bit alu with flags: operation codes, flag bit positions
// and the pipeline stage payload type; no dependencies
package ealu_pkg;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_ADC = 6'd1, OP_SUB = 6'd2, OP_SBC = 6'd3,
        OP_AND = 6'd4, OP_XOR = 6'd5, OP_OR = 6'd6, OP_CP = 6'd7,
        OP_INC = 6'd8, OP_DEC = 6'd9, OP_DAA = 6'd10, OP_CPL = 6'd11,
        OP_SCF = 6'd12, OP_CCF = 6'd13, OP_NEG = 6'd14,
        OP_RLCA = 6'd15, OP_RRCA = 6'd16, OP_RLA = 6'd17, OP_RRA = 6'd18,
        OP_RLC = 6'd19, OP_RRC = 6'd20, OP_RL = 6'd21, OP_RR = 6'd22,
        OP_SLA = 6'd23, OP_SRA = 6'd24, OP_SLL = 6'd25, OP_SRL = 6'd26,
        OP_BIT = 6'd27, OP_RES = 6'd28, OP_SET = 6'd29,
        OP_ADD16 = 6'd30, OP_ADC16 = 6'd31, OP_SBC16 = 6'd32,
        OP_RLD = 6'd33, OP_RRD = 6'd34
    } t_op;

    localparam int unsigned FlagS = 7;
    localparam int unsigned FlagZ = 6;
    localparam int unsigned FlagY = 5;
    localparam int unsigned FlagH = 4;
    localparam int unsigned FlagX = 3;
    localparam int unsigned FlagP = 2;
    localparam int unsigned FlagN = 1;
    localparam int unsigned FlagC = 0;

    // request as it travels between the three stages
    typedef struct packed {
        logic [5:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic [7:0]  fi;
        logic [2:0]  bi;
        logic [7:0]  xyb;
        logic [16:0] sum;   // raw adder output, bit 16 is carry/borrow
        logic [4:0]  hsum;  // low-nibble adder for 8-bit ops
        logic [12:0] hsum16;
        logic [15:0] res;
        logic [7:0]  f;
        logic [7:0]  aux;
    } t_stage;

    function automatic logic par_even(input logic [7:0] v);
        return ~^v;
    endfunction

    function automatic logic [7:0] szxyp(input logic [7:0] v);
        logic [7:0] f;
        f = v & 8'hA8;
        f[FlagZ] = (v == 8'h00);
        f[FlagP] = par_even(v);
        return f;
    endfunction

endpackage

/* rtl/eight_bit_alu_with_flags.sv */
// eight-bit alu with flags, top level; depends on ealu_pkg, ealu_arith,
// ealu_result and ealu_flags
// a request passes the adder, select and flags stage registers, in that order, before result valid
// throughput: one request per cycle; the whole pipe advances when the output
// register is empty or being taken, so a stall holds every stage in place
// reset: synchronous active low, clears all stage valid bits
module eight_bit_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [5:0]  i_op,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    input  logic [7:0]  i_flags_in,
    input  logic [2:0]  i_bit_index,
    input  logic [7:0]  i_bit_xy_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result,
    output logic [7:0]  o_flags_out,
    output logic [7:0]  o_aux_byte
);
    logic            en, v1, v2;
    ealu_pkg::t_stage d0, d1, d2;

    // pipe advances unless the output holds an untaken result
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    // pack request
    always_comb begin
        d0 = '0;
        d0.op = i_op;
        d0.a = i_operand_a;
        d0.b = i_operand_b;
        d0.fi = i_flags_in;
        d0.bi = i_bit_index;
        d0.xyb = i_bit_xy_byte;
    end

    ealu_arith u_arith (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(i_valid), .i_d(d0), .o_valid(v1), .o_d(d1)
    );

    ealu_result u_result (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(v1), .i_d(d1), .o_valid(v2), .o_d(d2)
    );

    ealu_flags u_flags (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(v2), .i_d(d2), .o_valid(o_valid),
        .o_res(o_result), .o_f(o_flags_out), .o_aux(o_aux_byte)
    );
endmodule

/* rtl/ealu_arith.sv */
// stage 1: operand decode and the shared 8/16-bit adder
// depends on ealu_pkg
module ealu_arith (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ealu_pkg::t_stage i_d,
    output logic            o_valid,
    output ealu_pkg::t_stage o_d
);
    logic            r_valid;
    ealu_pkg::t_stage r_d, n_d;
    logic [15:0] x, y;
    logic        c, sub;
    logic [7:0]  a8, b8;

    // pick adder operands per operation
    always_comb begin
        a8 = i_d.a[7:0];
        b8 = i_d.b[7:0];
        x = {8'h00, a8};
        y = {8'h00, b8};
        c = 1'b0;
        sub = 1'b0;
        case (i_d.op)
            ealu_pkg::OP_ADC: c = i_d.fi[ealu_pkg::FlagC];
            ealu_pkg::OP_SUB, ealu_pkg::OP_CP: sub = 1'b1;
            ealu_pkg::OP_SBC: begin
                sub = 1'b1;
                c = i_d.fi[ealu_pkg::FlagC];
            end
            ealu_pkg::OP_NEG: begin
                x = 16'h0000;
                y = {8'h00, a8};
                sub = 1'b1;
            end
            ealu_pkg::OP_ADD16: begin
                x = i_d.a;
                y = i_d.b;
            end
            ealu_pkg::OP_ADC16: begin
                x = i_d.a;
                y = i_d.b;
                c = i_d.fi[ealu_pkg::FlagC];
            end
            ealu_pkg::OP_SBC16: begin
                x = i_d.a;
                y = i_d.b;
                c = i_d.fi[ealu_pkg::FlagC];
                sub = 1'b1;
            end
            default: ;
        endcase
        n_d = i_d;
        if (sub) begin
            n_d.sum = {1'b0, x} - {1'b0, y} - {16'h0000, c};
            n_d.hsum = {1'b0, x[3:0]} - {1'b0, y[3:0]} - {4'h0, c};
            n_d.hsum16 = {1'b0, x[11:0]} - {1'b0, y[11:0]} - {12'h000, c};
        end else begin
            n_d.sum = {1'b0, x} + {1'b0, y} + {16'h0000, c};
            n_d.hsum = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'h0, c};
            n_d.hsum16 = {1'b0, x[11:0]} + {1'b0, y[11:0]} + {12'h000, c};
        end
        // 8-bit results carry/borrow sit at bit 8
        if (i_d.op != ealu_pkg::OP_ADD16 && i_d.op != ealu_pkg::OP_ADC16
            && i_d.op != ealu_pkg::OP_SBC16) begin
            n_d.sum[16] = n_d.sum[8];
        end
        n_d.res = 16'h0000;
        n_d.f = i_d.fi;
        n_d.aux = 8'h00;
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d = r_d;
endmodule

/* rtl/ealu_result.sv */
// stage 2: result byte/word selection and flags that do not need the result
// depends on ealu_pkg
module ealu_result (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ealu_pkg::t_stage i_d,
    output logic            o_valid,
    output ealu_pkg::t_stage o_d
);
    logic            r_valid;
    ealu_pkg::t_stage r_d, n_d;
    logic [7:0] a, b, s, t, msk;
    logic       cf, ci, dc;

    always_comb begin
        a = i_d.a[7:0];
        b = i_d.b[7:0];
        s = i_d.sum[7:0];
        cf = i_d.fi[ealu_pkg::FlagC];
        msk = 8'h01 << i_d.bi;
        t = 8'h00;
        dc = cf;
        ci = 1'b0;
        n_d = i_d;
        n_d.res = 16'h0000;
        n_d.aux = 8'h00;
        // carry out of rotates and shifts, kept in f[0] for stage 3
        n_d.f = i_d.fi;
        case (i_d.op)
            ealu_pkg::OP_ADD, ealu_pkg::OP_ADC, ealu_pkg::OP_SUB, ealu_pkg::OP_SBC,
            ealu_pkg::OP_NEG: n_d.res = {8'h00, s};
            ealu_pkg::OP_AND: n_d.res = {8'h00, a & b};
            ealu_pkg::OP_XOR: n_d.res = {8'h00, a ^ b};
            ealu_pkg::OP_OR:  n_d.res = {8'h00, a | b};
            ealu_pkg::OP_CP, ealu_pkg::OP_SCF, ealu_pkg::OP_CCF, ealu_pkg::OP_BIT:
                n_d.res = {8'h00, a};
            ealu_pkg::OP_INC: n_d.res = {8'h00, b + 8'h01};
            ealu_pkg::OP_DEC: n_d.res = {8'h00, b - 8'h01};
            ealu_pkg::OP_DAA: begin
                if (i_d.fi[ealu_pkg::FlagH] || a[3:0] > 4'd9) t[3:0] = 4'h6;
                if (cf || a > 8'h99) begin
                    t[7:4] = 4'h6;
                    dc = 1'b1;
                end
                if (i_d.fi[ealu_pkg::FlagN]) begin
                    n_d.res = {8'h00, a - t};
                    n_d.f[ealu_pkg::FlagH] = (a[3:0] < t[3:0]);
                end else begin
                    n_d.res = {8'h00, a + t};
                    n_d.f[ealu_pkg::FlagH] = ({1'b0, a[3:0]} + {1'b0, t[3:0]}) > 5'h0F;
                end
                n_d.f[ealu_pkg::FlagC] = dc;
            end
            ealu_pkg::OP_CPL: n_d.res = {8'h00, ~a};
            ealu_pkg::OP_RLCA: begin n_d.res = {8'h00, a[6:0], a[7]}; ci = a[7]; end
            ealu_pkg::OP_RRCA: begin n_d.res = {8'h00, a[0], a[7:1]}; ci = a[0]; end
            ealu_pkg::OP_RLA:  begin n_d.res = {8'h00, a[6:0], cf};   ci = a[7]; end
            ealu_pkg::OP_RRA:  begin n_d.res = {8'h00, cf, a[7:1]};   ci = a[0]; end
            ealu_pkg::OP_RLC:  begin n_d.res = {8'h00, b[6:0], b[7]}; ci = b[7]; end
            ealu_pkg::OP_RRC:  begin n_d.res = {8'h00, b[0], b[7:1]}; ci = b[0]; end
            ealu_pkg::OP_RL:   begin n_d.res = {8'h00, b[6:0], cf};   ci = b[7]; end
            ealu_pkg::OP_RR:   begin n_d.res = {8'h00, cf, b[7:1]};   ci = b[0]; end
            ealu_pkg::OP_SLA:  begin n_d.res = {8'h00, b[6:0], 1'b0}; ci = b[7]; end
            ealu_pkg::OP_SRA:  begin n_d.res = {8'h00, b[7], b[7:1]}; ci = b[0]; end
            ealu_pkg::OP_SLL:  begin n_d.res = {8'h00, b[6:0], 1'b1}; ci = b[7]; end
            ealu_pkg::OP_SRL:  begin n_d.res = {8'h00, 1'b0, b[7:1]}; ci = b[0]; end
            ealu_pkg::OP_RES: n_d.res = {8'h00, b & ~msk};
            ealu_pkg::OP_SET: n_d.res = {8'h00, b | msk};
            ealu_pkg::OP_ADD16, ealu_pkg::OP_ADC16, ealu_pkg::OP_SBC16:
                n_d.res = i_d.sum[15:0];
            ealu_pkg::OP_RLD: begin
                n_d.res = {8'h00, a[7:4], b[7:4]};
                n_d.aux = {b[3:0], a[3:0]};
            end
            ealu_pkg::OP_RRD: begin
                n_d.res = {8'h00, a[7:4], b[3:0]};
                n_d.aux = {a[3:0], b[7:4]};
            end
            default: ;
        endcase
        if (i_d.op >= ealu_pkg::OP_RLCA && i_d.op <= ealu_pkg::OP_SRL) begin
            n_d.f[ealu_pkg::FlagC] = ci;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d = r_d;
endmodule

/* rtl/ealu_flags.sv */
// stage 3: final flag byte from the result, into the output register
// depends on ealu_pkg
module ealu_flags (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  ealu_pkg::t_stage i_d,
    output logic            o_valid,
    output logic [15:0]     o_res,
    output logic [7:0]      o_f,
    output logic [7:0]      o_aux
);
    logic        r_valid;
    logic [15:0] r_res;
    logic [7:0]  r_f, r_aux, n_f;
    logic [7:0]  a, b, r, fi, xyb, hi, sz;
    logic        cf, t, ov8, ov16, add_ov;

    always_comb begin
        a = i_d.a[7:0];
        b = i_d.b[7:0];
        r = i_d.res[7:0];
        hi = i_d.res[15:8];
        fi = i_d.fi;
        xyb = i_d.xyb;
        cf = fi[ealu_pkg::FlagC];
        sz = ealu_pkg::szxyp(r);
        t = b[i_d.bi];
        add_ov = (i_d.op == ealu_pkg::OP_ADD || i_d.op == ealu_pkg::OP_ADC);
        if (add_ov) begin
            ov8 = ((a ^ r) & (b ^ r)) >= 8'h80;
        end else if (i_d.op == ealu_pkg::OP_NEG) begin
            ov8 = (a & r) >= 8'h80;
        end else begin
            ov8 = ((a ^ b) & (a ^ r)) >= 8'h80;
        end
        if (i_d.op == ealu_pkg::OP_ADC16) begin
            ov16 = ((i_d.a[15] ^ hi[7]) & (i_d.b[15] ^ hi[7]));
        end else begin
            ov16 = ((i_d.a[15] ^ i_d.b[15]) & (i_d.a[15] ^ hi[7]));
        end
        n_f = fi;
        case (i_d.op)
            ealu_pkg::OP_ADD, ealu_pkg::OP_ADC, ealu_pkg::OP_SUB, ealu_pkg::OP_SBC,
            ealu_pkg::OP_NEG, ealu_pkg::OP_CP: begin
                n_f = r & 8'hA8;
                n_f[ealu_pkg::FlagZ] = (r == 8'h00);
                n_f[ealu_pkg::FlagH] = i_d.hsum[4];
                n_f[ealu_pkg::FlagP] = ov8;
                n_f[ealu_pkg::FlagN] = !add_ov;
                n_f[ealu_pkg::FlagC] = i_d.sum[16];
                if (i_d.op == ealu_pkg::OP_CP) begin
                    n_f[ealu_pkg::FlagS] = i_d.sum[7];
                    n_f[ealu_pkg::FlagZ] = (i_d.sum[7:0] == 8'h00);
                    n_f[ealu_pkg::FlagP] = ((a ^ b) & (a ^ i_d.sum[7:0])) >= 8'h80;
                    n_f[ealu_pkg::FlagY] = b[5];
                    n_f[ealu_pkg::FlagX] = b[3];
                end
            end
            ealu_pkg::OP_AND: n_f = sz | 8'h10;
            ealu_pkg::OP_XOR, ealu_pkg::OP_OR: n_f = sz;
            ealu_pkg::OP_INC, ealu_pkg::OP_DEC: begin
                n_f = r & 8'hA8;
                n_f[ealu_pkg::FlagZ] = (r == 8'h00);
                n_f[ealu_pkg::FlagC] = cf;
                if (i_d.op == ealu_pkg::OP_INC) begin
                    n_f[ealu_pkg::FlagH] = (b[3:0] == 4'hF);
                    n_f[ealu_pkg::FlagP] = (b == 8'h7F);
                end else begin
                    n_f[ealu_pkg::FlagH] = (b[3:0] == 4'h0);
                    n_f[ealu_pkg::FlagP] = (b == 8'h80);
                    n_f[ealu_pkg::FlagN] = 1'b1;
                end
            end
            ealu_pkg::OP_DAA: begin
                n_f = sz;
                n_f[ealu_pkg::FlagN] = fi[ealu_pkg::FlagN];
                n_f[ealu_pkg::FlagH] = i_d.f[ealu_pkg::FlagH];
                n_f[ealu_pkg::FlagC] = i_d.f[ealu_pkg::FlagC];
            end
            ealu_pkg::OP_CPL: begin
                n_f = (fi & 8'hD7) | (r & 8'h28);
                n_f[ealu_pkg::FlagH] = 1'b1;
                n_f[ealu_pkg::FlagN] = 1'b1;
            end
            ealu_pkg::OP_SCF: n_f = (fi & 8'hC4) | (a & 8'h28) | 8'h01;
            ealu_pkg::OP_CCF: n_f = (fi & 8'hC4) | (a & 8'h28) | (cf ? 8'h10 : 8'h01);
            ealu_pkg::OP_RLCA, ealu_pkg::OP_RRCA, ealu_pkg::OP_RLA, ealu_pkg::OP_RRA:
                n_f = (fi & 8'hC4) | (r & 8'h28) | {7'h00, i_d.f[ealu_pkg::FlagC]};
            ealu_pkg::OP_RLC, ealu_pkg::OP_RRC, ealu_pkg::OP_RL, ealu_pkg::OP_RR,
            ealu_pkg::OP_SLA, ealu_pkg::OP_SRA, ealu_pkg::OP_SLL, ealu_pkg::OP_SRL:
                n_f = sz | {7'h00, i_d.f[ealu_pkg::FlagC]};
            ealu_pkg::OP_BIT: begin
                n_f = (xyb & 8'h28) | 8'h10 | {7'h00, cf};
                n_f[ealu_pkg::FlagZ] = !t;
                n_f[ealu_pkg::FlagP] = !t;
                n_f[ealu_pkg::FlagS] = (i_d.bi == 3'd7) && t;
            end
            ealu_pkg::OP_RES, ealu_pkg::OP_SET: n_f = fi;
            ealu_pkg::OP_ADD16: begin
                n_f = (fi & 8'hC4) | (hi & 8'h28);
                n_f[ealu_pkg::FlagH] = i_d.hsum16[12];
                n_f[ealu_pkg::FlagC] = i_d.sum[16];
            end
            ealu_pkg::OP_ADC16, ealu_pkg::OP_SBC16: begin
                n_f = hi & 8'hA8;
                n_f[ealu_pkg::FlagZ] = (i_d.res == 16'h0000);
                n_f[ealu_pkg::FlagH] = i_d.hsum16[12];
                n_f[ealu_pkg::FlagP] = ov16;
                n_f[ealu_pkg::FlagN] = (i_d.op == ealu_pkg::OP_SBC16);
                n_f[ealu_pkg::FlagC] = i_d.sum[16];
            end
            ealu_pkg::OP_RLD, ealu_pkg::OP_RRD: n_f = sz | {7'h00, cf};
            default: n_f = fi;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_res <= i_d.res;
            r_f <= n_f;
            r_aux <= i_d.aux;
        end
    end

    assign o_valid = r_valid;
    assign o_res = r_res;
    assign o_f = r_f;
    assign o_aux = r_aux;
endmodule

/* rtl/ealu_checker.sv */
// port-level checks for the eight-bit alu with flags, bound to the top level
// uses only the top-level ports, no package
module ealu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_result,
    input logic [7:0]  o_flags_out,
    input logic [7:0]  o_aux_byte
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result) && $stable(o_flags_out)
        && $stable(o_aux_byte))
        else $error("stalled result changed");

    // ready follows the output side
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready does not match output state");

    // a taken request, with the output kept open while it passes the stages, shows as a valid result
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready ##1 i_ready [*2] |=> o_valid)
        else $error("result missing after three cycles");

    // no result out of reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind eight_bit_alu_with_flags ealu_checker u_ealu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_result(o_result),
    .o_flags_out(o_flags_out), .o_aux_byte(o_aux_byte)
);
